// ----- design/rc4_stream_cipher_macros.svh -----
// Assertion macros for the RC4 stream cipher RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent holds a fixed number of cycles after the antecedent.
`define RC4_ASSERT_DELAY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ----- design/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher.
// No dependencies; every other design file but rc4_ram and the macro header imports this package.
`timescale 1ns / 1ps

package rc4_pkg;

	localparam int BYTE_W          = 8;
	localparam int TABLE_DEPTH     = 256;
	localparam int MAX_KEY_BYTES_D = 256;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t STEP_LAST = 8'hFF;

	// Item op codes
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// Sequencer states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_D_J  = 8'b0000_0010,
		ST_D_T  = 8'b0000_0100,
		ST_D_OUT= 8'b0000_1000,
		ST_K_RD = 8'b0001_0000,
		ST_K_J  = 8'b0010_0000,
		ST_K_W1 = 8'b0100_0000,
		ST_K_W2 = 8'b1000_0000
	} state_t;

	// Access to the permutation table
	typedef struct packed {
		logic  clear;
		logic  we;
		byte_t waddr;
		byte_t wdata;
		logic  re;
		byte_t raddr;
	} perm_req_t;

endpackage

// ----- design/rc4_stream_if.sv -----
// Valid/ready channel interfaces for the RC4 stream cipher.
// Depends on rc4_pkg for the byte type.
`timescale 1ns / 1ps

interface rc4_item_if import rc4_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  op;
	byte_t value;
	logic  last_key;

	modport source (output valid, op, value, last_key, input ready);
	modport sink (input valid, op, value, last_key, output ready);
endinterface

interface rc4_result_if import rc4_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_out;

	modport source (output valid, data_out, input ready);
	modport sink (input valid, data_out, output ready);
endinterface

// ----- design/rc4_stream_cipher.sv -----
// RC4 stream cipher top level: sequencer, key store and output register.
// Depends on rc4_pkg, rc4_stream_if, rc4_ram, rc4_perm and the assertion macro header.
`timescale 1ns / 1ps

// RC4 engine. Items arrive on "item": op = key (0) stores value as the next key byte,
// up to MAX_KEY_BYTES bytes, later bytes are dropped; last_key on a key item starts the
// key schedule, which resets the permutation to identity, runs 256 swap steps with the
// stored key bytes and then clears both generator indices and the key length, so the
// next key bytes start a fresh key. op = data (1) advances the generator once and
// returns value XOR keystream byte on "result"; key items return nothing. All work
// goes through one 8-bit adder and the single read port of the 256-entry permutation
// RAM. A data item passes ST_D_J, ST_D_T and ST_D_OUT (three dependent table reads,
// the first issued in the accept cycle, then a write-back in ST_D_OUT); a key item only
// the accept in ST_IDLE; a schedule runs ST_K_RD, ST_K_J, ST_K_W1, ST_K_W2 per swap step
// (four RAM accesses each). The block takes no item while it works on one. A finished
// byte waits in the output register, so the next item is accepted while it waits; only
// a second result finding that register still full stalls the engine. Reset restores
// the identity permutation at once through per-entry valid bits, with no clearing pass.

`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_D
) (
	input logic         clk,
	input logic         arst_n,
	rc4_item_if.sink    item,
	rc4_result_if.source result
);

	localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [LW-1:0] KEY_MAX = LW'(MAX_KEY_BYTES);

	state_t           state_q;
	byte_t            step_q;     // i of the generator, k of the schedule
	byte_t            mix_q;      // j of both
	logic [LW-1:0]    klen_q;
	logic [KAW-1:0]   kidx_q;     // k mod key length
	logic             out_valid_q;

	byte_t            value_q;
	byte_t            si_q;
	byte_t            sj_q;
	byte_t            sk_q;
	byte_t            t_q;
	byte_t            out_data_q;

	perm_req_t        perm_req;
	byte_t            perm_rd;
	byte_t            key_rd;
	logic             key_we;
	logic             item_acc;
	logic             key_full;
	logic             sched_start;
	logic             sched_done;
	logic             out_load;
	logic [LW-1:0]    kidx_inc;
	byte_t            kb;
	byte_t            ks;
	byte_t            add_a;
	byte_t            add_c;
	byte_t            add_sum;

	assign item.ready    = (state_q == ST_IDLE);
	assign item_acc      = item.valid && item.ready;
	assign key_full      = (klen_q >= KEY_MAX);
	assign key_we        = item_acc && (item.op == OP_KEY) && !key_full;
	assign sched_start   = item_acc && (item.op == OP_KEY) && item.last_key;
	assign sched_done    = (state_q == ST_K_W2) && (step_q == STEP_LAST);
	assign out_load      = (state_q == ST_D_OUT) && (!out_valid_q || result.ready);
	assign kidx_inc      = LW'(kidx_q) + LW'(1);

	// Guard against an empty key: treat it as one zero byte.
	assign kb = (klen_q == '0) ? '0 : key_rd;

	// Shared adder: j + S[i], S[i] + S[j], and j + S[k] + key byte.
	assign add_a   = (state_q == ST_D_T) ? si_q : mix_q;
	assign add_c   = (state_q == ST_K_J) ? kb : '0;
	assign add_sum = add_a + perm_rd + add_c;

	// Keystream byte: the read of S[t] saw the table before the swap, so patch it.
	always_comb begin
		if (t_q == mix_q) begin
			ks = si_q;
		end else if (t_q == step_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rd;
		end
	end

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_KEY_BYTES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(klen_q[KAW-1:0]),
		.wdata(item.value),
		.re   (state_q == ST_K_RD),
		.raddr(kidx_q),
		.rdata(key_rd)
	);

	rc4_perm u_perm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (perm_req),
		.rdata (perm_rd)
	);

	// Permutation table accesses per state.
	always_comb begin
		perm_req       = '0;
		perm_req.waddr = mix_q;
		perm_req.wdata = sk_q;
		perm_req.raddr = add_sum;
		case (state_q)
			ST_IDLE: begin
				// Prefetch S[i + 1] for the next data item.
				perm_req.re    = 1'b1;
				perm_req.raddr = step_q + BYTE_W'(1);
				perm_req.clear = sched_start;
			end
			ST_D_J: begin
				perm_req.re = 1'b1;
			end
			ST_D_T: begin
				perm_req.re    = 1'b1;
				perm_req.we    = 1'b1;
				perm_req.waddr = step_q;
				perm_req.wdata = perm_rd;
			end
			ST_D_OUT: begin
				perm_req.we    = 1'b1;
				perm_req.wdata = si_q;
			end
			ST_K_RD: begin
				perm_req.re    = 1'b1;
				perm_req.raddr = step_q;
			end
			ST_K_J: begin
				perm_req.re = 1'b1;
			end
			ST_K_W1: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = step_q;
				perm_req.wdata = perm_rd;
			end
			ST_K_W2: begin
				perm_req.we = 1'b1;
			end
			default: begin
				perm_req = '0;
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			mix_q       <= '0;
			klen_q      <= '0;
			kidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.op == OP_DATA) begin
							step_q  <= step_q + BYTE_W'(1);
							state_q <= ST_D_J;
						end else begin
							if (!key_full) begin
								klen_q <= klen_q + LW'(1);
							end
							if (item.last_key) begin
								step_q  <= '0;
								mix_q   <= '0;
								kidx_q  <= '0;
								state_q <= ST_K_RD;
							end
						end
					end
				end
				ST_D_J: begin
					mix_q   <= add_sum;
					state_q <= ST_D_T;
				end
				ST_D_T: begin
					state_q <= ST_D_OUT;
				end
				ST_D_OUT: begin
					// Hold here while the output register is still full.
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_K_RD: begin
					state_q <= ST_K_J;
				end
				ST_K_J: begin
					mix_q   <= add_sum;
					state_q <= ST_K_W1;
				end
				ST_K_W1: begin
					state_q <= ST_K_W2;
				end
				ST_K_W2: begin
					// step wraps back to zero after the last swap step.
					step_q <= step_q + BYTE_W'(1);
					if (kidx_inc >= klen_q) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_inc[KAW-1:0];
					end
					if (sched_done) begin
						mix_q   <= '0;
						klen_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_K_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			value_q <= item.value;
		end
		if (state_q == ST_D_J) begin
			si_q <= perm_rd;
		end
		if (state_q == ST_D_T) begin
			sj_q <= perm_rd;
			t_q  <= add_sum;
		end
		if (state_q == ST_K_J) begin
			sk_q <= perm_rd;
		end
		if (out_load) begin
			out_data_q <= value_q ^ ks;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.data_out = out_data_q;

	// After a data item is accepted, result.valid is checked to be high.
	`RC4_ASSERT_DELAY(a_data_result, item_acc && (item.op == OP_DATA), 4, result.valid, "data item gave no result")

	// The schedule leaves both indices and the key length at zero.
	`RC4_ASSERT_NEXT(a_sched_end, sched_done, (step_q == '0) && (mix_q == '0) && (klen_q == '0), "schedule end state wrong")

	// A key byte that finds the store full is dropped.
	`RC4_ASSERT_NEXT(a_key_drop, key_full && item_acc && (item.op == OP_KEY) && !item.last_key, klen_q == KEY_MAX, "key length moved when full")

endmodule

// ----- design/rc4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/rc4_perm.sv -----
// Permutation table: RAM plus per-entry valid bits; an invalid entry reads as its index.
// Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps

module rc4_perm import rc4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  perm_req_t req,
	output byte_t     rdata
);

	logic [TABLE_DEPTH-1:0] vld_q;
	logic                   rd_vld_q;
	byte_t                  rd_addr_q;
	byte_t                  ram_rdata;

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.we),
		.waddr(req.waddr),
		.wdata(req.wdata),
		.re   (req.re),
		.raddr(req.raddr),
		.rdata(ram_rdata)
	);

	// Clear drops every entry back to identity at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_vld_q  <= vld_q[req.raddr];
			rd_addr_q <= req.raddr;
		end
	end

	assign rdata = rd_vld_q ? ram_rdata : rd_addr_q;

endmodule
